// File: design/ksc_pkg.sv
// Shared types and constants for the keyword substitution cipher.
package ksc_pkg;

    localparam int ALPHA_LEN = 26;
    localparam int KEY_LEN   = 5;
    localparam int FILL_LEN  = ALPHA_LEN - KEY_LEN;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [CHAR_W-1:0] LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] LOWER_Z = 8'h7a;
    localparam logic [CHAR_W-1:0] UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_Z = 8'h5a;

    // Operation codes of the func field
    localparam logic FUNC_ENC = 1'b0;
    localparam logic FUNC_DEC = 1'b1;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [ALPHA_LEN-1:0][CHAR_W-1:0] tab_t;
    typedef logic [KEY_LEN-1:0][CHAR_W-1:0] key_t;

    // What the back end has to do with one character
    typedef enum logic [1:0] {
        OP_PASS = 2'd0,
        OP_ENC  = 2'd1,
        OP_DEC  = 2'd2
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
        char_t            ch;
    } item_t;

    // Table builder state
    typedef enum logic [1:0] {
        BUILD_IDLE = 2'b01,
        BUILD_RUN  = 2'b10
    } build_state_t;

    // Table contents and builder status, as seen by the rest of the block
    typedef struct packed {
        tab_t tab;
        logic busy;
    } tab_view_t;

endpackage

// File: design/ksc_table.sv
// Key registers and the sequencer that fills the substitution table.
module ksc_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ksc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ksc_pkg::CHAR_W-1:0]      cfg_data,
    output ksc_pkg::tab_view_t              view
);

    ksc_pkg::key_t                       key_reg;
    ksc_pkg::build_state_t               state_reg;
    logic [ksc_pkg::IDX_W-1:0]           cnt_reg;
    logic [ksc_pkg::IDX_W-1:0]           fill_reg;
    ksc_pkg::char_t                      ent_reg [ksc_pkg::FILL_LEN];

    ksc_pkg::char_t                      letter;
    logic                                in_key;
    logic                                do_fill;
    logic [ksc_pkg::IDX_W-1:0]           ent_idx;

    // Letter under test and whether the key already holds it
    always_comb
    begin
        letter = ksc_pkg::LOWER_A + ksc_pkg::CHAR_W'(cnt_reg);
        in_key = 1'b0;
        for (int k = 0; k < ksc_pkg::KEY_LEN; k++)
        begin
            if (key_reg[k] == letter)
            begin
                in_key = 1'b1;
            end
        end
        do_fill = (state_reg == ksc_pkg::BUILD_RUN) && !in_key
                  && (fill_reg < ksc_pkg::IDX_W'(ksc_pkg::ALPHA_LEN));
        ent_idx = fill_reg - ksc_pkg::IDX_W'(ksc_pkg::KEY_LEN);
    end

    // Key registers; any write restarts the sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ksc_pkg::KEY_LEN; k++)
            begin
                key_reg[k] <= ksc_pkg::LOWER_A + ksc_pkg::CHAR_W'(k);
            end
        end
        else if (cfg_we && (cfg_index < ksc_pkg::CFG_IDX_W'(ksc_pkg::KEY_LEN)))
        begin
            key_reg[cfg_index] <= cfg_data;
        end
    end

    // Sweep over a..z, one letter a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ksc_pkg::BUILD_RUN;
            cnt_reg   <= '0;
            fill_reg  <= ksc_pkg::IDX_W'(ksc_pkg::KEY_LEN);
        end
        else if (cfg_we)
        begin
            state_reg <= ksc_pkg::BUILD_RUN;
            cnt_reg   <= '0;
            fill_reg  <= ksc_pkg::IDX_W'(ksc_pkg::KEY_LEN);
        end
        else
        begin
            case (state_reg)
                ksc_pkg::BUILD_RUN:
                begin
                    if (do_fill)
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    if (cnt_reg == ksc_pkg::IDX_W'(ksc_pkg::ALPHA_LEN - 1))
                    begin
                        state_reg <= ksc_pkg::BUILD_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ksc_pkg::BUILD_IDLE:
                begin
                    state_reg <= ksc_pkg::BUILD_IDLE;
                end
                default:
                begin
                    state_reg <= ksc_pkg::BUILD_RUN;
                    cnt_reg   <= '0;
                    fill_reg  <= ksc_pkg::IDX_W'(ksc_pkg::KEY_LEN);
                end
            endcase
        end
    end

    // Fill entries; unfilled entries stay zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ksc_pkg::FILL_LEN; i++)
            begin
                ent_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < ksc_pkg::FILL_LEN; i++)
            begin
                ent_reg[i] <= '0;
            end
        end
        else if (do_fill)
        begin
            ent_reg[ent_idx] <= letter;
        end
    end

    // Full 26-entry view: key bytes first, then the filled letters
    always_comb
    begin
        for (int i = 0; i < ksc_pkg::KEY_LEN; i++)
        begin
            view.tab[i] = key_reg[i];
        end
        for (int i = 0; i < ksc_pkg::FILL_LEN; i++)
        begin
            view.tab[ksc_pkg::KEY_LEN + i] = ent_reg[i];
        end
        view.busy = (state_reg != ksc_pkg::BUILD_IDLE);
    end

endmodule

// File: design/ksc_front.sv
// Input side: accepts characters and classifies them for the back end.
module ksc_front (
    input  logic                       in_valid,
    input  logic                       func,
    input  logic [ksc_pkg::CHAR_W-1:0] char_in,
    input  logic                       busy,
    input  logic                       q_full,
    output logic                       in_stall,
    output logic                       push,
    output ksc_pkg::item_t             item
);

    ksc_pkg::char_t up_off;
    ksc_pkg::char_t lo_off;
    logic           is_upper;
    logic           is_lower;

    // Stall while the table is rebuilt or the queue has no room
    assign in_stall = busy || q_full;
    assign push     = in_valid && !in_stall;

    // Letter detection and alphabet index
    always_comb
    begin
        up_off   = char_in - ksc_pkg::UPPER_A;
        lo_off   = char_in - ksc_pkg::LOWER_A;
        is_upper = (char_in >= ksc_pkg::UPPER_A) && (char_in <= ksc_pkg::UPPER_Z);
        is_lower = (char_in >= ksc_pkg::LOWER_A) && (char_in <= ksc_pkg::LOWER_Z);
        item.ch  = char_in;
        item.idx = is_upper ? up_off[ksc_pkg::IDX_W-1:0] : lo_off[ksc_pkg::IDX_W-1:0];
        if (func == ksc_pkg::FUNC_DEC)
        begin
            item.op = ksc_pkg::OP_DEC;
        end
        else if (is_upper || is_lower)
        begin
            item.op = ksc_pkg::OP_ENC;
        end
        else
        begin
            item.op = ksc_pkg::OP_PASS;
        end
    end

endmodule

// File: design/ksc_fifo.sv
// Short queue of classified characters between front and back end.
module ksc_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ksc_pkg::item_t push_item,
    input  logic           pop,
    output ksc_pkg::item_t head,
    output logic           full,
    output logic           empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ksc_pkg::item_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/ksc_back.sv
// Back end: table lookup or reverse search, and the output register.
module ksc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ksc_pkg::item_t              head,
    input  logic                        q_empty,
    input  ksc_pkg::tab_view_t          view,
    input  logic                        out_stall,
    output logic                        pop,
    output logic                        out_valid,
    output logic [ksc_pkg::CHAR_W-1:0]  char_out
);

    logic           out_valid_reg;
    ksc_pkg::char_t char_out_reg;
    ksc_pkg::char_t res;
    logic           load;

    assign load      = !out_valid_reg || !out_stall;
    assign pop       = !q_empty && load;
    assign out_valid = out_valid_reg;
    assign char_out  = char_out_reg;

    // Substitution; reverse search keeps the lowest matching entry
    always_comb
    begin
        res = head.ch;
        case (head.op)
            ksc_pkg::OP_ENC:
            begin
                res = view.tab[head.idx];
            end
            ksc_pkg::OP_DEC:
            begin
                for (int j = ksc_pkg::ALPHA_LEN - 1; j >= 0; j--)
                begin
                    if (view.tab[j] == head.ch)
                    begin
                        res = ksc_pkg::LOWER_A + ksc_pkg::CHAR_W'(j);
                    end
                end
            end
            default:
            begin
                res = head.ch;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= !q_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            char_out_reg <= res;
        end
    end

endmodule

// File: design/keyword_substitution_cipher.sv
// Top level of the keyword substitution cipher.
//
// Input channel: in_valid/in_stall with func (0 encipher, 1 decipher) and
// char_in; one character per transaction. Output channel: out_valid/out_stall
// with char_out, one result per input transaction, in order.
// Configuration: cfg_we/cfg_index/cfg_data write key bytes 0..4; indexes
// 5..7 leave the key as it is. Each write restarts the table build (one letter
// a cycle through the builder's sweep) during which in_stall is high.
// After reset the same build runs with the default key "abcde".
// An accepted character passes through the queue and then the output
// register before it is presented on char_out.
// Throughput: one character per cycle while neither the table build nor a
// stall from the receiver holds the flow; the table lookup is combinational.
// When the receiver stalls, the result holds in the output register and
// the queue absorbs up to QUEUE_DEPTH more characters before in_stall rises.
module keyword_substitution_cipher #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ksc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ksc_pkg::CHAR_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            func,
    input  logic [ksc_pkg::CHAR_W-1:0]      char_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ksc_pkg::CHAR_W-1:0]      char_out
);

    ksc_pkg::tab_view_t view;
    ksc_pkg::item_t     push_item;
    ksc_pkg::item_t     head;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;

    ksc_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .view      (view)
    );

    ksc_front u_front (
        .in_valid (in_valid),
        .func     (func),
        .char_in  (char_in),
        .busy     (view.busy),
        .q_full   (q_full),
        .in_stall (in_stall),
        .push     (push),
        .item     (push_item)
    );

    ksc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    ksc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .view      (view),
        .out_stall (out_stall),
        .pop       (pop),
        .out_valid (out_valid),
        .char_out  (char_out)
    );

endmodule

// File: design/ksc_checker.sv
// Port-level checks for the keyword substitution cipher, bound to the top level.
module ksc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_we,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [ksc_pkg::CHAR_W-1:0]      char_out
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_out))
        else $error("stalled result changed");

    // A key write blocks input at the start and at the end of the table build
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> in_stall)
        else $error("input accepted right after key write");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> ##26 in_stall)
        else $error("table build ended early");

    // A result appearing on an idle output comes from an earlier input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without input transaction");

endmodule

bind keyword_substitution_cipher ksc_checker u_ksc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_out  (char_out)
);
